@@ rtl/core/linescan_edge_center_tracker_top_macros.svh @@
`ifndef LINESCAN_EDGE_CENTER_TRACKER_TOP_MACROS_SVH
`define LINESCAN_EDGE_CENTER_TRACKER_TOP_MACROS_SVH

// check a property on every clock edge outside reset
`define LECT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check a property on every clock edge, reset included
`define LECT_ASSERT_NR(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/core/lect_pkg.sv @@
`timescale 1ns / 1ps

package lect_pkg;

  localparam int PIXEL_BITS    = 12;
  localparam int FIRST_USED    = 10;
  localparam int DIFF_COUNT    = 106;
  localparam int AVERAGE_DEPTH = 8;

  localparam int POS_CAP  = FIRST_USED + DIFF_COUNT + 1;
  localparam int CENTRE   = DIFF_COUNT / 2;

  localparam int PixW     = PIXEL_BITS;
  localparam int DiffW    = PixW + 1;
  localparam int SpreadW  = 13;
  localparam int PosW     = $clog2(POS_CAP + 1);
  localparam int IdxW     = $clog2(DIFF_COUNT);
  localparam int OffW     = 7;
  localparam int WorkW    = IdxW + 2;
  localparam int AvgShift = $clog2(AVERAGE_DEPTH);
  localparam int PtrW     = AvgShift;
  localparam int SumW     = OffW + AvgShift + 1;
  localparam int CfgDataW = 13;
  localparam int ThrW     = 13;
  localparam int JumpW    = 7;

  localparam logic [ThrW-1:0]  THR_RESET  = ThrW'(100);
  localparam logic [JumpW-1:0] JUMP_RESET = JumpW'(15);

  typedef enum logic [0:0] {
    CFG_FAULT_THRESHOLD = 1'b0,
    CFG_JUMP_LIMIT      = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [DiffW-1:0] max_diff;
    logic signed [DiffW-1:0] min_diff;
    logic [IdxW-1:0]         max_idx;
    logic [IdxW-1:0]         min_idx;
  } line_sum_t;

  typedef struct packed {
    logic signed [OffW-1:0] offset;
    logic                   fault;
    logic [SpreadW-1:0]     spread;
  } line_res_t;

endpackage

@@ rtl/core/linescan_edge_center_tracker_top.sv @@
`timescale 1ns / 1ps

// Line-scan edge center tracker. Takes one pixel per clock with no gaps; the
// input stalls only when all three internal registers (line summary, center
// result, output) are full and the output is stalled. The line result passes
// through these registers in order: the edge tracker register loads at the
// edge that accepts the last pixel, then the center/spread register and then
// the jump-limit/moving-average output register load in turn.
// Configuration writes are always ready and take effect next clock; write them
// only while no line is in flight.
module linescan_edge_center_tracker_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [11:0]                       pixel_i,
  input  logic                              last_pixel_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [6:0]                 line_offset_o,
  output logic                              camera_fault_o,
  output logic [12:0]                       exposure_score_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [0:0]                        cfg_index_i,
  input  logic [lect_pkg::CfgDataW-1:0]     cfg_data_i
);

  logic [lect_pkg::ThrW-1:0]  thr_q;
  logic [lect_pkg::JumpW-1:0] jump_q;
  logic                       sum_valid, sum_ready, res_valid, res_ready;
  lect_pkg::line_sum_t        line_sum;
  lect_pkg::line_res_t        line_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= lect_pkg::THR_RESET;
      jump_q <= lect_pkg::JUMP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (lect_pkg::cfg_idx_e'(cfg_index_i))
        lect_pkg::CFG_FAULT_THRESHOLD: thr_q  <= cfg_data_i[lect_pkg::ThrW-1:0];
        lect_pkg::CFG_JUMP_LIMIT:      jump_q <= cfg_data_i[lect_pkg::JumpW-1:0];
        default: ;
      endcase
    end
  end

  lect_track u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_i      (pixel_i),
    .last_pixel_i (last_pixel_i),
    .sum_valid_o  (sum_valid),
    .sum_ready_i  (sum_ready),
    .sum_o        (line_sum)
  );

  lect_center u_center (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .sum_valid_i       (sum_valid),
    .sum_ready_o       (sum_ready),
    .sum_i             (line_sum),
    .fault_threshold_i (thr_q),
    .res_valid_o       (res_valid),
    .res_ready_i       (res_ready),
    .res_o             (line_res)
  );

  lect_filter u_filter (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .res_valid_i      (res_valid),
    .res_ready_o      (res_ready),
    .res_i            (line_res),
    .jump_limit_i     (jump_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .line_offset_o    (line_offset_o),
    .camera_fault_o   (camera_fault_o),
    .exposure_score_o (exposure_score_o)
  );

endmodule

@@ rtl/core/lect_track.sv @@
`timescale 1ns / 1ps
`include "linescan_edge_center_tracker_top_macros.svh"

module lect_track (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [lect_pkg::PixW-1:0]        pixel_i,
  input  logic                             last_pixel_i,
  output logic                             sum_valid_o,
  input  logic                             sum_ready_i,
  output lect_pkg::line_sum_t              sum_o
);

  logic [lect_pkg::PosW-1:0]         pos_q, pos_d;
  logic [lect_pkg::PixW-1:0]         prior_q;
  logic signed [lect_pkg::DiffW-1:0] max_q, max_d, min_q, min_d;
  logic [lect_pkg::IdxW-1:0]         maxi_q, maxi_d, mini_q, mini_d;
  logic                              sum_valid_q;
  lect_pkg::line_sum_t               sum_q;

  logic                              accept;
  logic                              in_win;
  logic [lect_pkg::IdxW-1:0]         k;
  logic signed [lect_pkg::DiffW-1:0] d;

  assign in_stall_o  = sum_valid_q & ~sum_ready_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign sum_valid_o = sum_valid_q;
  assign sum_o       = sum_q;

  always_comb begin
    in_win = (pos_q >= lect_pkg::PosW'(lect_pkg::FIRST_USED + 1)) &&
             (pos_q <= lect_pkg::PosW'(lect_pkg::FIRST_USED + lect_pkg::DIFF_COUNT));
    k      = lect_pkg::IdxW'(pos_q - lect_pkg::PosW'(lect_pkg::FIRST_USED + 1));
    d      = $signed({1'b0, prior_q}) - $signed({1'b0, pixel_i});
    max_d  = max_q;
    min_d  = min_q;
    maxi_d = maxi_q;
    mini_d = mini_q;
    if (in_win) begin
      if (k == '0) begin
        max_d  = d;
        min_d  = d;
        maxi_d = '0;
        mini_d = '0;
      end else begin
        if ((d > max_q) || ((d == max_q) && (maxi_q != '0))) begin
          max_d  = d;
          maxi_d = k;
        end
        if ((d < min_q) || ((d == min_q) && (mini_q != '0))) begin
          min_d  = d;
          mini_d = k;
        end
      end
    end
    pos_d = (pos_q < lect_pkg::PosW'(lect_pkg::POS_CAP)) ? pos_q + 1'b1 : pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      prior_q     <= '0;
      max_q       <= '0;
      min_q       <= '0;
      maxi_q      <= '0;
      mini_q      <= '0;
      sum_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        prior_q <= pixel_i;
        if (last_pixel_i) begin
          pos_q  <= '0;
          max_q  <= '0;
          min_q  <= '0;
          maxi_q <= '0;
          mini_q <= '0;
        end else begin
          pos_q  <= pos_d;
          max_q  <= max_d;
          min_q  <= min_d;
          maxi_q <= maxi_d;
          mini_q <= mini_d;
        end
      end
      if (accept && last_pixel_i) begin
        sum_valid_q <= 1'b1;
      end else if (sum_ready_i) begin
        sum_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_pixel_i) begin
      sum_q.max_diff <= max_d;
      sum_q.min_diff <= min_d;
      sum_q.max_idx  <= maxi_d;
      sum_q.min_idx  <= mini_d;
    end
  end

  `LECT_ASSERT_NR(a_pos_capped, (!rst_ni) || (pos_q <= lect_pkg::PosW'(lect_pkg::POS_CAP)), "position past cap")
  `LECT_ASSERT(a_last_restarts, accept && last_pixel_i |=> (pos_q == '0) && sum_valid_q, "line end not taken")
  `LECT_ASSERT(a_order, sum_valid_q && (max_q == '0) && (min_q == '0) |-> (max_q >= min_q), "tracker order")

endmodule

@@ rtl/core/lect_center.sv @@
`timescale 1ns / 1ps

module lect_center (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        sum_valid_i,
  output logic                        sum_ready_o,
  input  lect_pkg::line_sum_t         sum_i,
  input  logic [lect_pkg::ThrW-1:0]   fault_threshold_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output lect_pkg::line_res_t         res_o
);

  localparam logic signed [lect_pkg::WorkW-1:0] CentreW = lect_pkg::WorkW'(lect_pkg::CENTRE);

  logic                                res_valid_q;
  lect_pkg::line_res_t                 res_q, res_d;
  logic                                take;

  logic signed [lect_pkg::DiffW:0]     spread_w;
  logic signed [lect_pkg::IdxW:0]      di, di_b, half;
  logic signed [lect_pkg::WorkW-1:0]   raw;

  assign sum_ready_o = ~res_valid_q | res_ready_i;
  assign take        = sum_valid_i & sum_ready_o;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    spread_w     = {sum_i.max_diff[lect_pkg::DiffW-1], sum_i.max_diff} -
                   {sum_i.min_diff[lect_pkg::DiffW-1], sum_i.min_diff};
    di           = $signed({1'b0, sum_i.max_idx}) - $signed({1'b0, sum_i.min_idx});
    di_b         = di + $signed({{lect_pkg::IdxW{1'b0}}, di[lect_pkg::IdxW]});
    half         = di_b >>> 1;
    raw          = $signed({2'b00, sum_i.min_idx}) + {half[lect_pkg::IdxW], half} - CentreW;
    res_d.spread = lect_pkg::SpreadW'(spread_w);
    res_d.fault  = (lect_pkg::SpreadW'(spread_w) < fault_threshold_i);
    res_d.offset = lect_pkg::OffW'(raw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (sum_ready_o) begin
      res_valid_q <= sum_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

endmodule

@@ rtl/core/lect_filter.sv @@
`timescale 1ns / 1ps
`include "linescan_edge_center_tracker_top_macros.svh"

module lect_filter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              res_valid_i,
  output logic                              res_ready_o,
  input  lect_pkg::line_res_t               res_i,
  input  logic [lect_pkg::JumpW-1:0]        jump_limit_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [lect_pkg::OffW-1:0]  line_offset_o,
  output logic                              camera_fault_o,
  output logic [lect_pkg::SpreadW-1:0]      exposure_score_o
);

  localparam logic signed [lect_pkg::SumW-1:0] Bias =
    lect_pkg::SumW'(lect_pkg::AVERAGE_DEPTH - 1);
  localparam logic signed [lect_pkg::OffW-1:0] OffMin = -lect_pkg::OffW'(lect_pkg::CENTRE);
  localparam logic signed [lect_pkg::OffW-1:0] OffMax =
    lect_pkg::OffW'(lect_pkg::DIFF_COUNT - 1 - lect_pkg::CENTRE);

  logic signed [lect_pkg::OffW-1:0]   ring_q [lect_pkg::AVERAGE_DEPTH];
  logic [lect_pkg::PtrW-1:0]          ptr_q, ptr_d;
  logic signed [lect_pkg::SumW-1:0]   sum_q, sum_d;
  logic signed [lect_pkg::OffW-1:0]   prev_q, cur;
  logic                               out_valid_q;
  logic signed [lect_pkg::OffW-1:0]   offset_q;
  logic                               fault_q;
  logic [lect_pkg::SpreadW-1:0]       score_q;
  logic                               take;

  logic signed [lect_pkg::WorkW-1:0]  prev_w, raw_w, lim_w, lo, hi, delta, delta_b, half;
  logic signed [lect_pkg::SumW-1:0]   sum_b, avg_w;

  assign res_ready_o      = ~out_valid_q | ~out_stall_i;
  assign take             = res_valid_i & res_ready_o;
  assign out_valid_o      = out_valid_q;
  assign line_offset_o    = offset_q;
  assign camera_fault_o   = fault_q;
  assign exposure_score_o = score_q;

  always_comb begin
    prev_w  = lect_pkg::WorkW'(prev_q);
    raw_w   = lect_pkg::WorkW'(res_i.offset);
    lim_w   = $signed({{(lect_pkg::WorkW - lect_pkg::JumpW){1'b0}}, jump_limit_i});
    lo      = prev_w - lim_w;
    hi      = prev_w + lim_w;
    delta   = raw_w - prev_w;
    delta_b = delta + $signed({{(lect_pkg::WorkW - 1){1'b0}}, delta[lect_pkg::WorkW-1]});
    half    = delta_b >>> 1;
    if ((raw_w < lo) || (raw_w > hi)) begin
      cur = lect_pkg::OffW'(prev_w + half);
    end else begin
      cur = res_i.offset;
    end
    sum_d = sum_q - lect_pkg::SumW'(ring_q[ptr_q]) + lect_pkg::SumW'(cur);
    sum_b = sum_d[lect_pkg::SumW-1] ? sum_d + Bias : sum_d;
    avg_w = sum_b >>> lect_pkg::AvgShift;
    ptr_d = (ptr_q == lect_pkg::PtrW'(lect_pkg::AVERAGE_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lect_pkg::AVERAGE_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
      ptr_q       <= '0;
      sum_q       <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        ring_q[ptr_q] <= cur;
        ptr_q         <= ptr_d;
        sum_q         <= sum_d;
        prev_q        <= cur;
      end
      if (res_ready_o) begin
        out_valid_q <= res_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      offset_q <= lect_pkg::OffW'(avg_w);
      fault_q  <= res_i.fault;
      score_q  <= res_i.spread;
    end
  end

  `LECT_ASSERT(a_take_fills, take |=> out_valid_q, "accepted line result not shown")
  `LECT_ASSERT(a_ptr_step, take |=> (ptr_q == $past(ptr_d)), "ring pointer did not advance")
  `LECT_ASSERT_NR(a_prev_range, (!rst_ni) || ((prev_q >= OffMin) && (prev_q <= OffMax)), "offset out of range")

endmodule

@@ tb/tb_linescan_edge_center_tracker_top.sv @@
`timescale 1ns / 1ps

module tb_linescan_edge_center_tracker_top;

  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_PIXELS   = 40;

  typedef enum int {
    LINE_FLAT,
    LINE_STRIPE,
    LINE_RAMP,
    LINE_ALT,
    LINE_NOISE
  } line_kind_e;

  typedef struct {
    line_kind_e kind;
    int         len;
    int         lvl_a;
    int         lvl_b;
    int         at;
    int         width;
    int         noise;
    bit         has_score;
    bit         has_offset;
    int         t_offset;
    bit         t_fault;
    int         t_score;
  } line_desc_t;

  typedef struct {
    logic [11:0]       pixel;
    logic              last;
    bit                has_score;
    bit                has_offset;
    logic signed [6:0] t_offset;
    logic              t_fault;
    logic [12:0]       t_score;
  } pixel_item_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [11:0]       pixel_i;
  logic              last_pixel_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic signed [6:0] line_offset_o;
  logic              camera_fault_o;
  logic [12:0]       exposure_score_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [0:0]        cfg_index_i;
  logic [lect_pkg::CfgDataW-1:0] cfg_data_i;

  // predictor state
  logic [lect_pkg::ThrW-1:0]        thr_cfg = lect_pkg::THR_RESET;
  logic [lect_pkg::JumpW-1:0]       jump_cfg = lect_pkg::JUMP_RESET;
  logic [6:0]                       pos_q = '0;
  logic [11:0]                      prior_px = '0;
  logic signed [12:0]               hi_diff = '0;
  logic signed [12:0]               lo_diff = '0;
  logic [6:0]                       hi_idx = '0;
  logic [6:0]                       lo_idx = '0;
  logic signed [lect_pkg::OffW-1:0] offset_ring [lect_pkg::AVERAGE_DEPTH] = '{default: '0};
  logic [lect_pkg::PtrW-1:0]        ring_ptr = '0;
  logic signed [lect_pkg::OffW-1:0] prev_off = '0;

  lect_pkg::line_res_t expected_q [$];
  pixel_item_t         pixel_q [$];
  pixel_item_t         cur_item;
  int                  error_count = 0;
  int                  burst_left = 0;
  int                  stuck_cycles = 0;
  bit                  hold_request = 1'b0;

  line_desc_t directed_lines [12] = '{
    '{LINE_FLAT,     1,    0,    0,   0,  0,  0, 1, 1, -3, 1,    0},
    '{LINE_FLAT,    11, 4095,    0,   0,  0,  0, 1, 0,  0, 1,    0},
    '{LINE_FLAT,    12,    0,    0,   0,  0,  0, 1, 0,  0, 1,    0},
    '{LINE_STRIPE, 117, 4095,    0,  40, 20,  0, 1, 0,  0, 0, 8190},
    '{LINE_STRIPE, 117,    0, 4095,  11,  1,  0, 1, 0,  0, 0, 8190},
    '{LINE_STRIPE, 117,    0, 4095, 116,  1,  0, 1, 0,  0, 0, 4095},
    '{LINE_RAMP,   117,    0,   32,   0,  0,  0, 1, 0,  0, 1,    0},
    '{LINE_ALT,    117,    0, 4095,   0,  0,  0, 1, 0,  0, 0, 8190},
    '{LINE_STRIPE, 125,    0, 4095, 118,  5,  0, 1, 0,  0, 1,    0},
    '{LINE_NOISE,   60,    0,    0,   0,  0,  0, 0, 0,  0, 0,    0},
    '{LINE_STRIPE,  64, 3000,  200,  30, 10,  5, 0, 0,  0, 0,    0},
    '{LINE_FLAT,     1, 4095,    0,   0,  0,  0, 1, 0,  0, 1,    0}
  };

  linescan_edge_center_tracker_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pixel_i         (pixel_i),
    .last_pixel_i    (last_pixel_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .line_offset_o   (line_offset_o),
    .camera_fault_o  (camera_fault_o),
    .exposure_score_o(exposure_score_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  task automatic track_pixel(input logic [11:0] px, input logic last,
                             output bit emit, output lect_pkg::line_res_t res);
    int k, d, spread, cur, prev, lim, acc;
    emit = 1'b0;
    res = '0;
    if (pos_q >= lect_pkg::FIRST_USED + 1 &&
        pos_q <= lect_pkg::FIRST_USED + lect_pkg::DIFF_COUNT) begin
      k = int'(pos_q) - lect_pkg::FIRST_USED - 1;
      d = int'(prior_px) - int'(px);
      if (k == 0) begin
        hi_diff = 13'(d);
        hi_idx = '0;
        lo_diff = 13'(d);
        lo_idx = '0;
      end else begin
        if (d > hi_diff || (d == hi_diff && hi_idx != 0)) begin
          hi_diff = 13'(d);
          hi_idx = 7'(k);
        end
        if (d < lo_diff || (d == lo_diff && lo_idx != 0)) begin
          lo_diff = 13'(d);
          lo_idx = 7'(k);
        end
      end
    end
    prior_px = px;
    if (pos_q < lect_pkg::POS_CAP) pos_q = pos_q + 1'b1;
    if (last) begin
      spread = int'(hi_diff) - int'(lo_diff);
      cur = int'(lo_idx) + (int'(hi_idx) - int'(lo_idx)) / 2 - lect_pkg::CENTRE;
      prev = int'(prev_off);
      lim = int'(jump_cfg);
      if (cur < prev - lim || cur > prev + lim) cur = prev + (cur - prev) / 2;
      offset_ring[ring_ptr] = lect_pkg::OffW'(cur);
      ring_ptr = ring_ptr + 1'b1;
      acc = 0;
      for (int i = 0; i < lect_pkg::AVERAGE_DEPTH; i++) acc += int'(offset_ring[i]);
      prev_off = lect_pkg::OffW'(cur);
      res.offset = lect_pkg::OffW'(acc / lect_pkg::AVERAGE_DEPTH);
      res.fault = spread < int'(thr_cfg);
      res.spread = lect_pkg::SpreadW'(spread);
      emit = 1'b1;
      pos_q = '0;
      hi_diff = '0;
      hi_idx = '0;
      lo_diff = '0;
      lo_idx = '0;
    end
  endtask

  task automatic queue_line(input line_desc_t d);
    pixel_item_t it;
    int base, v;
    for (int p = 0; p < d.len; p++) begin
      case (d.kind)
        LINE_FLAT:   base = d.lvl_a;
        LINE_STRIPE: base = (p >= d.at && p < d.at + d.width) ? d.lvl_b : d.lvl_a;
        LINE_RAMP:   base = (d.lvl_a + p * d.lvl_b) % 4096;
        LINE_ALT:    base = (p % 2 == 0) ? d.lvl_a : d.lvl_b;
        default:     base = int'($urandom_range(0, 4095));
      endcase
      v = base;
      if (d.noise > 0) v = v + int'($urandom_range(0, 2 * d.noise)) - d.noise;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      it.pixel = 12'(v);
      it.last = (p == d.len - 1);
      it.has_score = d.has_score && it.last;
      it.has_offset = d.has_offset && it.last;
      it.t_offset = 7'(d.t_offset);
      it.t_fault = d.t_fault;
      it.t_score = 13'(d.t_score);
      pixel_q.push_back(it);
    end
  endtask

  function automatic line_desc_t random_line();
    line_desc_t d;
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 60) d.len = int'($urandom_range(117, 130));
    else if (r < 90) d.len = int'($urandom_range(1, 116));
    else d.len = int'($urandom_range(131, 250));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: d.kind = LINE_STRIPE;
      5, 6:          d.kind = LINE_NOISE;
      7:             d.kind = LINE_RAMP;
      8:             d.kind = LINE_ALT;
      default:       d.kind = LINE_FLAT;
    endcase
    d.lvl_a = int'($urandom_range(0, 4095));
    d.lvl_b = int'($urandom_range(0, 4095));
    d.at = int'($urandom_range(0, 130));
    d.width = int'($urandom_range(1, 60));
    case ($urandom_range(0, 2))
      0:       d.noise = 0;
      1:       d.noise = int'($urandom_range(0, 20));
      default: d.noise = int'($urandom_range(0, 400));
    endcase
    d.has_score = 1'b0;
    d.has_offset = 1'b0;
    d.t_offset = 0;
    d.t_fault = 1'b0;
    d.t_score = 0;
    return d;
  endfunction

  task automatic drive_queued();
    int gap;
    @(negedge clk_i);
    while (pixel_q.size() != 0) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 9) == 0) ? int'($urandom_range(20, 40))
                                          : int'($urandom_range(1, 6));
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
        burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(200, 400))
                                                 : int'($urandom_range(1, 30));
      end
      burst_left--;
      cur_item = pixel_q.pop_front();
      in_valid_i <= 1'b1;
      pixel_i <= cur_item.pixel;
      last_pixel_i <= cur_item.last;
      do @(posedge clk_i); while (in_stall_o);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic write_register(input lect_pkg::cfg_idx_e idx, input int value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= lect_pkg::CfgDataW'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == lect_pkg::CFG_FAULT_THRESHOLD) thr_cfg = lect_pkg::ThrW'(value);
    else jump_cfg = lect_pkg::JumpW'(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // predict on every accepted pixel, check every accepted result
  always @(posedge clk_i) begin
    bit                  emit;
    lect_pkg::line_res_t res;
    lect_pkg::line_res_t want;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      track_pixel(cur_item.pixel, cur_item.last, emit, res);
      if (emit) begin
        if (cur_item.has_score) begin
          res.fault = cur_item.t_fault;
          res.spread = cur_item.t_score;
        end
        if (cur_item.has_offset) res.offset = cur_item.t_offset;
        expected_q.push_back(res);
      end
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing pending, line_offset", int'(line_offset_o), 0);
      end else begin
        want = expected_q.pop_front();
        if (line_offset_o !== want.offset)
          report_mismatch("line_offset", int'(line_offset_o), int'(want.offset));
        if (camera_fault_o !== want.fault)
          report_mismatch("camera_fault", int'(camera_fault_o), int'(want.fault));
        if (exposure_score_o !== want.spread)
          report_mismatch("exposure_score", int'(exposure_score_o), int'(want.spread));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("[linescan_edge_center_tracker_top] ERROR");
      $finish;
    end
  end

  initial begin
    int seg_left;
    int stall_pct;
    seg_left = 0;
    stall_pct = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      if (seg_left == 0) begin
        seg_left = int'($urandom_range(1, 64));
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 30;
          2:       stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      seg_left--;
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    int thr, jmp;
    line_desc_t d;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    pixel_i = '0;
    last_pixel_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = lect_pkg::CFG_FAULT_THRESHOLD;
    cfg_data_i = '0;
    cur_item = '{default: '0};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_lines[i]) queue_line(directed_lines[i]);
    drive_queued();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          thr = 0;
          jmp = 0;
        end
        1: begin
          thr = 8190;
          jmp = 127;
        end
        2: begin
          thr = int'($urandom_range(0, 8190));
          jmp = int'($urandom_range(0, 127));
        end
        default: begin
          thr = int'($urandom_range(0, 300));
          jmp = int'($urandom_range(0, 20));
        end
      endcase
      wait_idle();
      write_register(lect_pkg::CFG_FAULT_THRESHOLD, thr);
      write_register(lect_pkg::CFG_JUMP_LIMIT, jmp);
      if (ph == 0) begin
        // flood with short lines so the output backs up during the hold
        repeat (12) begin
          d = random_line();
          d.len = int'($urandom_range(1, 4));
          queue_line(d);
        end
        hold_request = 1'b1;
      end
      do begin
        queue_line(random_line());
      end while (pixel_q.size() < PHASE_PIXELS);
      drive_queued();
    end

    wait_idle();
    if (error_count == 0) begin
      $display("[linescan_edge_center_tracker_top] OK");
    end else begin
      $display("[linescan_edge_center_tracker_top] ERROR");
    end
    $finish;
  end

endmodule
